// ===== sv/msp_pkg.sv =====
// shared types, codes and constants for the masked shortest-path engine
package msp_pkg;

	localparam logic [29:0] UNREACHABLE = 30'h3f3f3f3f;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [5:0]  end_a;
		logic [5:0]  end_b;
		logic [15:0] edge_weight;
		logic [31:0] blocked_mask;
	} in_t;

	typedef struct packed {
		logic        status;
		logic [29:0] distance;
	} out_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DEC, S_A1, S_A2, S_A3, S_A4,
		S_QI, S_QPOP, S_QTAKE, S_QHEAD, S_QLINK, S_QEDGE, S_QRELAX,
		S_QT1, S_QT2, S_DONE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_in;
		logic clr_graph;
		logic res_zero;
		logic res_full;
		logic res_dist;
		logic a_rd;
		logic a_wr;
		logic b_rd;
		logic b_wr;
		logic q_init;
		logic q_pop;
		logic q_take;
		logic q_head;
		logic q_link;
		logic q_edge;
		logic q_relax;
		logic t_rd;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [1:0] opcode;
		logic       add_ok;
		logic       add_full;
		logic       fill_zero;
		logic       link_zero;
		logic       blocked;
	} sts_t;

endpackage

// ===== sv/msp_ram.sv =====
// generic single-write, single-read ram with registered read data
module msp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/msp_ctrl.sv =====
// controller state machine for graph edits and the relaxation walk
module msp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  msp_pkg::sts_t sts,
	output msp_pkg::cmd_t cmd,
	output msp_pkg::state_t state
);
	import msp_pkg::*;

	state_t state_q, state_d;

	assign state = state_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_DEC;
			S_DEC: begin
				unique case (sts.opcode)
					OP_ADD: begin
						if (sts.add_ok && !sts.add_full) state_d = S_A1;
						else state_d = S_DONE;
					end
					OP_QUERY: state_d = S_QI;
					default: state_d = S_DONE;
				endcase
			end
			S_A1: state_d = S_A2;
			S_A2: state_d = S_A3;
			S_A3: state_d = S_A4;
			S_A4: state_d = S_DONE;
			S_QI: state_d = S_QPOP;
			S_QPOP: begin
				if (sts.fill_zero) state_d = S_QT1;
				else state_d = S_QTAKE;
			end
			S_QTAKE: state_d = S_QHEAD;
			S_QHEAD: state_d = S_QLINK;
			S_QLINK: begin
				if (sts.link_zero) state_d = S_QPOP;
				else state_d = S_QEDGE;
			end
			S_QEDGE: begin
				if (sts.blocked) state_d = S_QLINK;
				else state_d = S_QRELAX;
			end
			S_QRELAX: state_d = S_QLINK;
			S_QT1: state_d = S_QT2;
			S_QT2: state_d = S_DONE;
			S_DONE: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// command decode
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			S_DEC: begin
				unique case (sts.opcode)
					OP_CLEAR: begin
						cmd.clr_graph = 1'b1;
						cmd.res_zero  = 1'b1;
					end
					OP_ADD: begin
						cmd.res_full = sts.add_ok && sts.add_full;
						cmd.res_zero = !sts.add_ok;
					end
					OP_QUERY: cmd.q_init = 1'b1;
					default: cmd.res_zero = 1'b1;
				endcase
			end
			S_A1: cmd.a_rd = 1'b1;
			S_A2: cmd.a_wr = 1'b1;
			S_A3: cmd.b_rd = 1'b1;
			S_A4: begin
				cmd.b_wr     = 1'b1;
				cmd.res_zero = 1'b1;
			end
			S_QPOP: cmd.q_pop = !sts.fill_zero;
			S_QTAKE: cmd.q_take = 1'b1;
			S_QHEAD: cmd.q_head = 1'b1;
			S_QLINK: cmd.q_link = !sts.link_zero;
			S_QEDGE: cmd.q_edge = 1'b1;
			S_QRELAX: cmd.q_relax = 1'b1;
			S_QT1: cmd.t_rd = 1'b1;
			S_QT2: cmd.res_dist = 1'b1;
			S_DONE: out_valid = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== sv/msp_dp.sv =====
// datapath: adjacency store, distance table, work queue and result register
module msp_dp #(
	parameter int MAX_VERTICES = 32,
	parameter int MAX_EDGES    = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  msp_pkg::in_t  in_data,
	input  logic          cfg_we,
	input  logic [5:0]    cfg_data,
	input  msp_pkg::cmd_t cmd,
	output msp_pkg::sts_t sts,
	output msp_pkg::out_t res
);
	import msp_pkg::*;

	localparam int VW  = $clog2(MAX_VERTICES + 1);
	localparam int AW  = $clog2(MAX_VERTICES);
	localparam int EW  = $clog2(MAX_EDGES + 1);
	localparam int EAW = $clog2(MAX_EDGES);
	localparam int RW  = VW + 16 + EW;

	in_t                     in_q;
	logic [5:0]              vcount_q;
	logic [MAX_VERTICES-1:0] head_valid_q;
	logic [MAX_VERTICES-1:0] dist_valid_q;
	logic [MAX_VERTICES-1:0] inq_q;
	logic                    hv_q;
	logic                    dv_q;
	logic [EW-1:0]           total_q;
	logic [AW-1:0]           rd_q, wr_q;
	logic [VW-1:0]           fill_q;
	logic [29:0]             dp_q;
	logic [29:0]             cand_q;
	logic [EW-1:0]           link_q;
	logic [AW-1:0]           v_q;
	out_t                    res_q;

	logic [VW-1:0] used;
	logic [AW-1:0] a_addr, b_addr, p_addr, e_addr, t_addr;
	logic [EW-1:0] headv;
	logic [29:0]   distv;

	// ram ports
	logic          head_we;
	logic [AW-1:0] head_waddr, head_raddr;
	logic [EW-1:0] head_rdata;
	logic          edge_we;
	logic [EAW-1:0] edge_waddr, edge_raddr;
	logic [RW-1:0] edge_wdata, edge_rdata;
	logic          dist_we;
	logic [AW-1:0] dist_waddr, dist_raddr;
	logic [29:0]   dist_wdata, dist_rdata;
	logic          fifo_we;
	logic [AW-1:0] fifo_waddr;
	logic [VW-1:0] fifo_wdata, fifo_rdata;

	logic [VW-1:0] e_target;
	logic [15:0]   e_cost;
	logic [EW-1:0] e_next;
	logic          relax_hit;
	logic          push_ok;

	// effective vertex count, saturated to the legal range
	always_comb begin
		if (vcount_q == 6'd0) used = VW'(1);
		else if (32'(vcount_q) > MAX_VERTICES) used = VW'(MAX_VERTICES);
		else used = VW'(vcount_q);
	end

	assign a_addr = AW'(32'(in_q.end_a) - 1);
	assign b_addr = AW'(32'(in_q.end_b) - 1);
	assign p_addr = AW'(32'(fifo_rdata) - 1);
	assign t_addr = AW'(32'(used) - 1);
	assign {e_target, e_cost, e_next} = edge_rdata;
	assign e_addr = AW'(32'(e_target) - 1);
	assign headv  = hv_q ? head_rdata : '0;
	assign distv  = dv_q ? dist_rdata : UNREACHABLE;

	// status back to the controller
	always_comb begin
		sts.opcode    = in_q.opcode;
		sts.add_ok    = (in_q.end_a != 6'd0) && (32'(in_q.end_a) <= MAX_VERTICES) &&
			(in_q.end_b != 6'd0) && (32'(in_q.end_b) <= MAX_VERTICES);
		sts.add_full  = (32'(total_q) + 2) > MAX_EDGES;
		sts.fill_zero = (fill_q == '0);
		sts.link_zero = (link_q == '0);
		sts.blocked   = (e_target > used) ||
			((32'(e_target) <= 32) && in_q.blocked_mask[5'(32'(e_target) - 1)]);
	end

	// list head ram port muxing
	always_comb begin
		head_we    = cmd.a_wr || cmd.b_wr;
		head_waddr = cmd.a_wr ? a_addr : b_addr;
		if (cmd.a_rd) head_raddr = a_addr;
		else if (cmd.b_rd) head_raddr = b_addr;
		else head_raddr = p_addr;
	end

	// edge ram port muxing
	always_comb begin
		edge_we    = cmd.a_wr || cmd.b_wr;
		edge_waddr = EAW'(total_q);
		if (cmd.a_wr) edge_wdata = {VW'(in_q.end_b), in_q.edge_weight, headv};
		else edge_wdata = {VW'(in_q.end_a), in_q.edge_weight, headv};
		edge_raddr = EAW'(32'(link_q) - 1);
	end

	// relaxation decision
	assign relax_hit = distv > cand_q;
	assign push_ok   = !inq_q[v_q] && (32'(fill_q) < MAX_VERTICES);

	// distance ram port muxing
	always_comb begin
		dist_we    = cmd.q_init || (cmd.q_relax && relax_hit);
		dist_waddr = cmd.q_init ? '0 : v_q;
		dist_wdata = cmd.q_init ? '0 : cand_q;
		if (cmd.q_take) dist_raddr = p_addr;
		else if (cmd.q_edge) dist_raddr = e_addr;
		else dist_raddr = t_addr;
	end

	// work queue ram port muxing
	always_comb begin
		fifo_we    = cmd.q_init || (cmd.q_relax && relax_hit && push_ok);
		fifo_waddr = cmd.q_init ? '0 : wr_q;
		fifo_wdata = cmd.q_init ? VW'(1) : VW'(32'(v_q) + 1);
	end

	msp_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_head (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(EW'(32'(total_q) + 1)),
		.raddr(head_raddr), .rdata(head_rdata)
	);

	msp_ram #(.WIDTH(RW), .DEPTH(MAX_EDGES)) u_edge (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
		.raddr(edge_raddr), .rdata(edge_rdata)
	);

	msp_ram #(.WIDTH(30), .DEPTH(MAX_VERTICES)) u_dist (
		.clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
		.raddr(dist_raddr), .rdata(dist_rdata)
	);

	msp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_fifo (
		.clk(clk), .we(fifo_we), .waddr(fifo_waddr), .wdata(fifo_wdata),
		.raddr(rd_q), .rdata(fifo_rdata)
	);

	// input beat and payload working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) in_q <= in_data;
		hv_q <= head_valid_q[head_raddr];
		dv_q <= dist_valid_q[dist_raddr];
		if (cmd.q_head) dp_q <= distv;
		if (cmd.q_edge) begin
			cand_q <= dp_q + 30'(e_cost);
			v_q    <= e_addr;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 6'd32;
		end else if (cfg_we) begin
			vcount_q <= cfg_data;
		end
	end

	// graph control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= '0;
			total_q      <= '0;
		end else if (cmd.clr_graph) begin
			head_valid_q <= '0;
			total_q      <= '0;
		end else if (cmd.a_wr || cmd.b_wr) begin
			head_valid_q[head_waddr] <= 1'b1;
			total_q                  <= EW'(32'(total_q) + 1);
		end
	end

	// query control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_valid_q <= '0;
			inq_q        <= '0;
			rd_q         <= '0;
			wr_q         <= '0;
			fill_q       <= '0;
			link_q       <= '0;
		end else begin
			if (cmd.q_init) begin
				dist_valid_q <= MAX_VERTICES'(1);
				inq_q        <= MAX_VERTICES'(1);
				rd_q         <= '0;
				wr_q         <= (MAX_VERTICES == 1) ? '0 : AW'(1);
				fill_q       <= VW'(1);
			end
			if (cmd.q_pop) begin
				rd_q   <= (32'(rd_q) == MAX_VERTICES - 1) ? '0 : AW'(32'(rd_q) + 1);
				fill_q <= VW'(32'(fill_q) - 1);
			end
			if (cmd.q_take) inq_q[p_addr] <= 1'b0;
			if (cmd.q_head) link_q <= headv;
			if (cmd.q_edge) link_q <= e_next;
			if (cmd.q_relax && relax_hit) begin
				dist_valid_q[v_q] <= 1'b1;
				if (push_ok) begin
					inq_q[v_q] <= 1'b1;
					wr_q       <= (32'(wr_q) == MAX_VERTICES - 1) ? '0 : AW'(32'(wr_q) + 1);
					fill_q     <= VW'(32'(fill_q) + 1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.res_zero) res_q <= '0;
		else if (cmd.res_full) res_q <= '{status: 1'b1, distance: '0};
		else if (cmd.res_dist) res_q <= '{status: 1'b0, distance: distv};
	end

	assign res = res_q;

endmodule

// ===== sv/masked_shortest_path_engine.sv =====
// Masked shortest-path engine: one result beat per input beat. An add does
// one list-head read and one edge write per direction. A query runs a
// queue-driven relaxation from vertex 1: accept and setup, then for each
// vertex popped a walk of its adjacency entries, then a final empty-queue
// check and the target read. No clearing pass is needed after reset.
// Configuration writes are taken at any time but must only arrive while idle.
module masked_shortest_path_engine #(
	parameter int MAX_VERTICES = 32,
	parameter int MAX_EDGES    = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  msp_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output msp_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [5:0]    cfg_data
);
	import msp_pkg::*;

	cmd_t   cmd;
	sts_t   sts;
	state_t state;

	assign cfg_ready = 1'b1;

	// sequencer
	msp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd),
		.state(state)
	);

	// storage and arithmetic
	msp_dp #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_data),
		.cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
		.cmd(cmd), .sts(sts), .res(out_data)
	);

	// a result beat and a new input beat never overlap
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input ready while result pending");

	// an accepted beat blocks further input the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("input taken twice");

	// a full flag never comes with a distance
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status) |-> (out_data.distance == '0))
		else $error("full status with distance");

	// the result is shown only in the done state
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state == S_DONE)) else $error("result outside done state");

endmodule

// ===== sim/masked_shortest_path_engine_test.sv =====
// testbench for the masked shortest-path engine: directed and random items against a predictor
module masked_shortest_path_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import msp_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic ST_OK = 1'b0;
	localparam logic ST_FULL = 1'b1;
	localparam int VERT_LIMIT = 32;
	localparam int EDGE_LIMIT = 256;
	localparam int STALL_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [5:0] cfg_data;

	masked_shortest_path_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// shadow copy of the graph store and the vertex count register
	int unsigned list_start[VERT_LIMIT + 1];
	int unsigned slot_to[EDGE_LIMIT];
	int unsigned slot_cost[EDGE_LIMIT];
	int unsigned slot_next[EDGE_LIMIT];
	int unsigned slots_used;
	logic [5:0] vertex_reg;

	out_t awaited_results[$];
	int mismatches;
	int stall_cycles;
	bit idle_on;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// store one directed adjacency entry
	function automatic void link_slot(int unsigned from, int unsigned to, int unsigned cost);
		slot_to[slots_used] = to;
		slot_cost[slots_used] = cost;
		slot_next[slots_used] = list_start[from];
		list_start[from] = slots_used + 1;
		slots_used++;
	endfunction

	// queue-driven relaxation from vertex 1 to the target vertex
	function automatic logic [29:0] relax_from_source(logic [31:0] mask);
		int unsigned used;
		int unsigned best[VERT_LIMIT + 1];
		bit queued[VERT_LIMIT + 1];
		int unsigned pending[VERT_LIMIT];
		int unsigned rd, wr, fill, p, link, v, cand;
		bit blk;
		used = (vertex_reg == 0) ? 1 : (vertex_reg > VERT_LIMIT) ? VERT_LIMIT : vertex_reg;
		for (int i = 0; i <= VERT_LIMIT; i++) begin
			best[i] = UNREACHABLE;
			queued[i] = 1'b0;
		end
		best[1] = 0;
		pending[0] = 1;
		rd = 0;
		wr = 1;
		fill = 1;
		queued[1] = 1'b1;
		while (fill > 0) begin
			p = pending[rd];
			rd = (rd + 1) % VERT_LIMIT;
			fill--;
			queued[p] = 1'b0;
			link = list_start[p];
			while (link != 0 && link <= EDGE_LIMIT) begin
				v = slot_to[link - 1];
				cand = best[p] + slot_cost[link - 1];
				link = slot_next[link - 1];
				blk = (v < 1 || v > used) || (v <= 32 && mask[v - 1]);
				if (!blk && best[v] > cand) begin
					best[v] = cand;
					if (!queued[v] && fill < VERT_LIMIT) begin
						pending[wr] = v;
						wr = (wr + 1) % VERT_LIMIT;
						fill++;
						queued[v] = 1'b1;
					end
				end
			end
		end
		return best[used][29:0];
	endfunction

	// expected result of one accepted item, updating the shadow store
	function automatic out_t shortest_path_result(in_t it);
		out_t r;
		r.status = ST_OK;
		r.distance = '0;
		case (it.opcode)
			OP_CLEAR: begin
				for (int i = 0; i <= VERT_LIMIT; i++) list_start[i] = 0;
				slots_used = 0;
			end
			OP_ADD: begin
				if (it.end_a >= 1 && it.end_a <= VERT_LIMIT &&
				    it.end_b >= 1 && it.end_b <= VERT_LIMIT) begin
					if (slots_used + 2 > EDGE_LIMIT) begin
						r.status = ST_FULL;
					end else begin
						link_slot(it.end_a, it.end_b, it.edge_weight);
						link_slot(it.end_b, it.end_a, it.edge_weight);
					end
				end
			end
			OP_QUERY: r.distance = relax_from_source(it.blocked_mask);
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// send one item beat, with random gaps in front of it
	task automatic send_item(in_t it);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!(in_valid && in_ready));
		awaited_results.push_back(shortest_path_result(it));
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// change the vertex count while the block is idle
	task automatic set_vertex_count(logic [5:0] value);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		vertex_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_t make_item(logic [1:0] op, logic [5:0] a, logic [5:0] b,
	                                  logic [15:0] w, logic [31:0] m);
		in_t it;
		it.opcode = op;
		it.end_a = a;
		it.end_b = b;
		it.edge_weight = w;
		it.blocked_mask = m;
		return it;
	endfunction

	// random item weighted toward adds among the vertices in use, then queries
	function automatic in_t random_item(int unsigned vc);
		in_t it;
		int unsigned r;
		it = make_item(2'($urandom), 6'($urandom), 6'($urandom), 16'($urandom), $urandom);
		r = $urandom_range(99);
		it.opcode = (r < 3) ? OP_CLEAR : (r < 58) ? OP_ADD : (r < 96) ? OP_QUERY : OP_UNUSED;
		if ($urandom_range(9) != 0) begin
			it.end_a = 6'($urandom_range(1, vc));
			it.end_b = 6'($urandom_range(1, vc));
		end
		if ($urandom_range(1) != 0) it.edge_weight = 16'($urandom_range(0, 20));
		case ($urandom_range(3))
			0: it.blocked_mask = '0;
			1: it.blocked_mask = $urandom;
			default: it.blocked_mask = $urandom & $urandom & $urandom;
		endcase
		return it;
	endfunction

	// result side: random stalls and comparison with the oldest expectation
	always @(negedge clk) begin
		out_ready <= !(idle_on && $urandom_range(99) < 13);
	end

	always @(posedge clk) begin
		out_t want;
		if (out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected beat", out_data, 0);
			end else begin
				want = awaited_results.pop_front();
				if (out_data.status !== want.status)
					report_mismatch("status", out_data.status, want.status);
				if (out_data.distance !== want.distance)
					report_mismatch("distance", out_data.distance, want.distance);
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic test_directed();
		send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
		send_item(make_item(OP_QUERY, 0, 0, 0, 0));
		send_item(make_item(OP_ADD, 1, 2, 0, 32'hffffffff));
		send_item(make_item(OP_ADD, 2, 32, 16'hffff, 0));
		send_item(make_item(OP_QUERY, 0, 0, 0, 0));
		send_item(make_item(OP_QUERY, 0, 0, 0, 32'h0000_0002));
		send_item(make_item(OP_QUERY, 0, 0, 0, 32'h8000_0000));
		send_item(make_item(OP_QUERY, 63, 63, 16'hffff, 32'h7fff_ffff));
		send_item(make_item(OP_ADD, 0, 5, 3, 0));
		send_item(make_item(OP_ADD, 33, 5, 3, 0));
		send_item(make_item(OP_ADD, 1, 63, 3, 0));
		send_item(make_item(OP_ADD, 1, 1, 7, 0));
		send_item(make_item(OP_UNUSED, 63, 63, 16'hffff, 32'hffffffff));
		send_item(make_item(OP_ADD, 1, 3, 1, 0));
		send_item(make_item(OP_ADD, 3, 32, 1, 0));
		send_item(make_item(OP_QUERY, 0, 0, 0, 0));
		send_item(make_item(OP_QUERY, 0, 0, 0, 32'h0000_0004));
		set_vertex_count(1);
		send_item(make_item(OP_QUERY, 0, 0, 0, 32'hffffffff));
		set_vertex_count(0);
		send_item(make_item(OP_QUERY, 0, 0, 0, 0));
		set_vertex_count(63);
		send_item(make_item(OP_QUERY, 0, 0, 0, 0));
		set_vertex_count(2);
		send_item(make_item(OP_QUERY, 0, 0, 0, 0));
		send_item(make_item(OP_QUERY, 0, 0, 0, 32'h0000_0002));
	endtask

	// fill the edge store past its end
	task automatic test_store_full();
		set_vertex_count(32);
		send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
		for (int i = 0; i < 131; i++)
			send_item(make_item(OP_ADD, 6'($urandom_range(1, 32)), 6'($urandom_range(1, 32)),
			                    16'($urandom), 0));
		send_item(make_item(OP_QUERY, 0, 0, 0, 0));
		send_item(make_item(OP_QUERY, 0, 0, 0, $urandom));
		send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
		send_item(make_item(OP_ADD, 1, 32, 9, 0));
		send_item(make_item(OP_QUERY, 0, 0, 0, 0));
	endtask

	// random graphs under several vertex counts
	task automatic test_random_graphs(int phases, int per_phase);
		logic [5:0] vc;
		for (int p = 0; p < phases; p++) begin
			case ($urandom_range(5))
				0: vc = 6'd32;
				1: vc = 6'($urandom_range(33, 63));
				2: vc = 6'($urandom_range(0, 1));
				default: vc = 6'($urandom_range(2, 12));
			endcase
			set_vertex_count(vc);
			send_item(make_item(OP_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom),
			                    $urandom));
			for (int i = 0; i < per_phase; i++)
				send_item(random_item((vc == 0) ? 1 : (vc > 32) ? 32 : vc));
		end
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		test_random_graphs(2, 40);
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatches = 0;
		stall_cycles = 0;
		idle_on = 1'b1;
		vertex_reg = 6'd32;
		slots_used = 0;
		for (int i = 0; i <= VERT_LIMIT; i++) list_start[i] = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_store_full();
		test_random_graphs(8, 55);
		test_back_to_back();

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
